>>> rtl/scstk_pkg.sv
// shared types and constants of the stable cost sort with top-k selection
`timescale 1ns / 1ps

package scstk_pkg;

	// store size and field widths
	localparam int MAX_ENTRIES = 64;
	localparam int COST_W      = 16;
	localparam int ROW_W       = 6;
	localparam int COL_W       = 6;
	localparam int CFG_W       = 7;
	localparam int MAX_COLS    = 64;
	localparam int IDX_W       = $clog2(MAX_ENTRIES);
	localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
	localparam int CMP_W       = (CFG_W > CNT_W) ? CFG_W : CNT_W;

	// stream payload widths, padded to whole bytes
	localparam int IN_DATA_W   = ((COST_W + 7) / 8) * 8;
	localparam int OUT_FIELD_W = ROW_W + COL_W + COST_W;
	localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;

	// register indexes of the configuration port
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_NUM_COLS   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_KEEP_COUNT = 1'b1;

	// one stored entry
	typedef struct packed {
		logic [ROW_W-1:0]  row;
		logic [COL_W-1:0]  col;
		logic [COST_W-1:0] cost;
	} entry_t;

	// commands from the controller to the datapath
	typedef struct packed {
		logic accept;    // latch key, advance counters, flag overflow
		logic ins_key;   // write key at insertion slot, bump count
		logic ins_rd;    // read the entry below the insertion slot
		logic shift;     // move read entry up one slot, read the next one down
		logic emit_rd;   // read sorted entry at emit index
		logic emit_ld;   // load output register from read data
		logic emit_next; // step emit index
		logic clear;     // end of run
	} cmd_t;

	// status from the datapath to the controller
	typedef struct packed {
		logic full;   // store holds MAX_ENTRIES entries
		logic j_zero; // insertion slot at the bottom
		logic j_one;  // insertion slot one above the bottom
		logic gt;     // read entry costs more than the key
		logic fin;    // emit index is the last of the burst
		logic last;   // current item closes the run
	} sts_t;

endpackage

>>> rtl/scstk_dpath.sv
// datapath: entry store, insertion walk, counters, config and output register
`timescale 1ns / 1ps

module scstk_dpath (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  scstk_pkg::cmd_t                       cmd,
	output scstk_pkg::sts_t                       sts,
	input  logic [scstk_pkg::COST_W-1:0]          in_cost,
	input  logic                                  in_last,
	input  logic                                  cfg_we,
	input  logic [scstk_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [scstk_pkg::CFG_W-1:0]           cfg_wdata,
	output scstk_pkg::entry_t                     out_entry,
	output logic                                  out_drop,
	output logic                                  out_fin
);

	// sorted entry store
	scstk_pkg::entry_t mem [scstk_pkg::MAX_ENTRIES];
	scstk_pkg::entry_t rdata_q;
	scstk_pkg::entry_t key_q;
	scstk_pkg::entry_t wdata;
	logic [scstk_pkg::IDX_W-1:0] raddr;
	logic                        we;
	logic                        re;

	logic [scstk_pkg::CNT_W-1:0] count_q;
	logic [scstk_pkg::IDX_W-1:0] j_q;
	logic [scstk_pkg::IDX_W-1:0] i_q;
	logic [scstk_pkg::ROW_W-1:0] row_q;
	logic [scstk_pkg::COL_W-1:0] col_q;
	logic                        ovf_q;
	logic                        last_q;
	logic [scstk_pkg::CFG_W-1:0] num_cols_q;
	logic [scstk_pkg::CFG_W-1:0] keep_q;

	logic [scstk_pkg::CFG_W-1:0] cols;
	logic [scstk_pkg::CFG_W-1:0] col_nxt;
	logic [scstk_pkg::CNT_W-1:0] n_emit;

	scstk_pkg::entry_t out_q;
	logic              drop_q;
	logic              fin_q;

	// clamp of the column count
	always_comb begin
		if (num_cols_q == '0) begin
			cols = scstk_pkg::CFG_W'(1);
		end else if (num_cols_q > scstk_pkg::CFG_W'(scstk_pkg::MAX_COLS)) begin
			cols = scstk_pkg::CFG_W'(scstk_pkg::MAX_COLS);
		end else begin
			cols = num_cols_q;
		end
	end

	assign col_nxt = scstk_pkg::CFG_W'(col_q) + scstk_pkg::CFG_W'(1);

	// burst length
	always_comb begin
		if (keep_q != '0 &&
		    scstk_pkg::CMP_W'(keep_q) < scstk_pkg::CMP_W'(count_q)) begin
			n_emit = scstk_pkg::CNT_W'(keep_q);
		end else begin
			n_emit = count_q;
		end
	end

	// memory port muxing
	always_comb begin
		if (cmd.shift) begin
			raddr = j_q - scstk_pkg::IDX_W'(2);
		end else if (cmd.ins_rd) begin
			raddr = j_q - scstk_pkg::IDX_W'(1);
		end else begin
			raddr = i_q;
		end
		we    = cmd.ins_key | cmd.shift;
		re    = cmd.shift | cmd.ins_rd | cmd.emit_rd;
		wdata = cmd.shift ? rdata_q : key_q;
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[j_q] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// key and output payload
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			key_q.row  <= row_q;
			key_q.col  <= col_q;
			key_q.cost <= in_cost;
		end
		if (cmd.emit_ld) begin
			out_q  <= rdata_q;
			drop_q <= ovf_q;
			fin_q  <= sts.fin;
		end
	end

	// control state of the run
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			j_q        <= '0;
			i_q        <= '0;
			row_q      <= '0;
			col_q      <= '0;
			ovf_q      <= 1'b0;
			last_q     <= 1'b0;
			num_cols_q <= scstk_pkg::CFG_W'(1);
			keep_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_idx)
					scstk_pkg::CFG_NUM_COLS:   num_cols_q <= cfg_wdata;
					scstk_pkg::CFG_KEEP_COUNT: keep_q     <= cfg_wdata;
					default: ;
				endcase
			end
			if (cmd.accept) begin
				j_q    <= count_q[scstk_pkg::IDX_W-1:0];
				last_q <= in_last;
				if (sts.full) begin
					ovf_q <= 1'b1;
				end
				if (col_nxt >= cols) begin
					col_q <= '0;
					row_q <= row_q + scstk_pkg::ROW_W'(1);
				end else begin
					col_q <= col_nxt[scstk_pkg::COL_W-1:0];
				end
			end
			if (cmd.ins_key) begin
				count_q <= count_q + scstk_pkg::CNT_W'(1);
			end
			if (cmd.shift) begin
				j_q <= j_q - scstk_pkg::IDX_W'(1);
			end
			if (cmd.emit_next) begin
				i_q <= i_q + scstk_pkg::IDX_W'(1);
			end
			if (cmd.clear) begin
				count_q <= '0;
				i_q     <= '0;
				row_q   <= '0;
				col_q   <= '0;
				ovf_q   <= 1'b0;
			end
		end
	end

	assign sts.full   = (count_q == scstk_pkg::CNT_W'(scstk_pkg::MAX_ENTRIES));
	assign sts.j_zero = (j_q == '0);
	assign sts.j_one  = (j_q == scstk_pkg::IDX_W'(1));
	assign sts.gt     = ($signed(rdata_q.cost) > $signed(key_q.cost));
	assign sts.fin    = ((scstk_pkg::CNT_W'(i_q) + scstk_pkg::CNT_W'(1)) == n_emit);
	assign sts.last   = last_q;

	assign out_entry = out_q;
	assign out_drop  = drop_q;
	assign out_fin   = fin_q;

endmodule

>>> rtl/scstk_ctrl.sv
// controller: sequences insertion walks and the emission burst
`timescale 1ns / 1ps

module scstk_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_last,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output scstk_pkg::cmd_t cmd,
	input  scstk_pkg::sts_t sts
);

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_INS  = 3'd1;
	localparam logic [2:0] S_CMP  = 3'd2;
	localparam logic [2:0] S_ERD  = 3'd3;
	localparam logic [2:0] S_ELD  = 3'd4;
	localparam logic [2:0] S_EOUT = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.accept = 1'b1;
					if (!sts.full) begin
						state_nxt = S_INS;
					end else if (in_last) begin
						state_nxt = S_ERD;
					end
				end
			end
			S_INS: begin
				if (sts.j_zero) begin
					cmd.ins_key = 1'b1;
					state_nxt   = sts.last ? S_ERD : S_IDLE;
				end else begin
					cmd.ins_rd = 1'b1;
					state_nxt  = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.gt) begin
					cmd.shift = 1'b1;
					if (sts.j_one) begin
						state_nxt = S_INS;
					end
				end else begin
					cmd.ins_key = 1'b1;
					state_nxt   = sts.last ? S_ERD : S_IDLE;
				end
			end
			S_ERD: begin
				cmd.emit_rd = 1'b1;
				state_nxt   = S_ELD;
			end
			S_ELD: begin
				cmd.emit_ld = 1'b1;
				state_nxt   = S_EOUT;
			end
			S_EOUT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					if (sts.fin) begin
						cmd.clear = 1'b1;
						state_nxt = S_IDLE;
					end else begin
						cmd.emit_next = 1'b1;
						state_nxt     = S_ERD;
					end
				end
			end
			default: state_nxt = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> rtl/stable_cost_sort_top_k.sv
// top level of the stable cost sort with top-k selection
`timescale 1ns / 1ps

// channel  | dir | handshake                | payload
// s_       | in  | s_tvalid / s_tready      | s_tdata cost, s_tlast end of matrix
// m_       | out | m_tvalid / m_tready      | m_tdata factory/period/cost, m_tuser dropped,
//          |     |                          | m_tlast last result of the burst
// cfg_     | in  | cfg_valid / cfg_ready    | cfg_index register, cfg_data value
//
// an entry is taken in idle and walks down the store, moving up each stored entry with a
// higher cost, and is written above the first one that costs no more; an entry that meets
// a full store is dropped and flags the burst; the walk uses the store's single read port
// each result of the burst goes through read, load and transaction, stalling on m_tready
// input is not taken during an insertion walk or during the burst
// asynchronous reset clears counters, flags and the state machine; the store is not cleared
// cfg_ready is always high; writes take effect in the next cycle

module stable_cost_sort_top_k (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave stream
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [scstk_pkg::IN_DATA_W-1:0]      s_tdata,   // [15:0] cost
	input  logic                                 s_tlast,
	// master stream
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [scstk_pkg::OUT_DATA_W-1:0]     m_tdata,   // factory, period, entry_cost
	output logic                                 m_tuser,   // dropped
	output logic                                 m_tlast,
	// configuration writes
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [scstk_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [scstk_pkg::CFG_W-1:0]          cfg_data
);

	scstk_pkg::cmd_t   cmd;
	scstk_pkg::sts_t   sts;
	scstk_pkg::entry_t out_entry;
	logic              out_drop;
	logic              out_fin;

	assign cfg_ready = 1'b1;

	// sequencing of insertion and emission
	scstk_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_tvalid),
		.in_last   (s_tlast),
		.in_ready  (s_tready),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.cmd       (cmd),
		.sts       (sts)
	);

	// store, counters and output register
	scstk_dpath u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_cost   (s_tdata[scstk_pkg::COST_W-1:0]),
		.in_last   (s_tlast),
		.cfg_we    (cfg_valid & cfg_ready),
		.cfg_idx   (cfg_index),
		.cfg_wdata (cfg_data),
		.out_entry (out_entry),
		.out_drop  (out_drop),
		.out_fin   (out_fin)
	);

	// pack the result, factory in the lowest bits
	assign m_tdata = scstk_pkg::OUT_DATA_W'({out_entry.cost, out_entry.col, out_entry.row});
	assign m_tuser = out_drop;
	assign m_tlast = out_fin;

	// input and output never handshake in the same cycle
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(m_tvalid && s_tready))
		else $error("input ready while a result is offered");

	// the last entry of a matrix always starts work that blocks input
	a_last_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && s_tlast) |=> !s_tready)
		else $error("input still ready after the last entry");

	// after the final result the block is ready for the next matrix
	a_burst_end: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tready && m_tlast) |=> (s_tready && !m_tvalid))
		else $error("block not idle after the final result");

endmodule
